// File: src/assert_macros.svh
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define HRHP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define HRHP_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define HRHP_ASSERT(lbl, clk, rst, prop)

`define HRHP_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// File: src/hrhp_pkg.sv
package hrhp_pkg;

   localparam int METH_COUNT = 7;
   localparam int METH_MAX   = 7;

   localparam logic [3:0] PH_METHOD     = 4'd0;
   localparam logic [3:0] PH_URL        = 4'd1;
   localparam logic [3:0] PH_VERSION    = 4'd2;
   localparam logic [3:0] PH_VER_SKIP   = 4'd3;
   localparam logic [3:0] PH_KEY_FIRST  = 4'd4;
   localparam logic [3:0] PH_KEY        = 4'd5;
   localparam logic [3:0] PH_COLON_SKIP = 4'd6;
   localparam logic [3:0] PH_VALUE      = 4'd7;
   localparam logic [3:0] PH_VAL_SKIP   = 4'd8;
   localparam logic [3:0] PH_LINE_CHECK = 4'd9;
   localparam logic [3:0] PH_END_SKIP   = 4'd10;
   localparam logic [3:0] PH_BODY       = 4'd11;

   localparam logic [2:0] ROLE_METHOD  = 3'd0;
   localparam logic [2:0] ROLE_URL     = 3'd1;
   localparam logic [2:0] ROLE_VERSION = 3'd2;
   localparam logic [2:0] ROLE_KEY     = 3'd3;
   localparam logic [2:0] ROLE_VALUE   = 3'd4;
   localparam logic [2:0] ROLE_BODY    = 3'd5;
   localparam logic [2:0] ROLE_SKIP    = 3'd6;

   localparam logic [2:0] CODE_ERROR = 3'd7;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;

   localparam logic [METH_COUNT-1:0] CAND_ALL = '1;

   // method names, in match priority order
   localparam logic [7:0] METH_TEXT [METH_COUNT][METH_MAX] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S"},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00}
   };

   localparam logic [2:0] METH_LEN [METH_COUNT] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd5
   };

   typedef struct packed {
      logic [2:0] role;
      logic       field_start;
   } tag_type;

endpackage

// File: src/hrhp_if.sv
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface hrhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] role;
   logic       field_start;
   logic [2:0] method_code;
   logic       last_out;

   modport source (output valid, byte_out, role, field_start, method_code, last_out,
                   input ready);
   modport sink (input valid, byte_out, role, field_start, method_code, last_out,
                 output ready);
endinterface

// File: src/http_request_head_parser_unit.sv
// HTTP request head tagger: each request byte is passed through with its role (method, url,
// version, header key, header value, body or skipped delimiter), a field start flag and the
// method code found by prefix match of the first seven bytes. A byte with last_byte set ends
// the request and the next byte starts a new one. One byte is taken every clock cycle while
// results are taken; a byte's result is offered from the result register, which is loaded
// from the input register when the byte advances, and the tagging state is updated
// in the single step between the two registers. A result held by the sink holds a byte in the
// input register, and the request side then stalls for as long as the result waits.
`include "assert_macros.svh"

module http_request_head_parser_unit (
   input  logic            clock,
   input  logic            reset,
   hrhp_req_if.sink        req_bus,
   hrhp_rsp_if.source      rsp_bus
);

   logic              in_valid_ff;
   logic [7:0]        in_data_ff;
   logic              in_last_ff;
   logic              advance;
   logic [2:0]        method_code;
   hrhp_pkg::tag_type tag;

   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;
   hrhp_pkg::tag_type out_tag_ff;
   logic [2:0]        out_code_ff;
   logic              out_last_ff;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_data_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   hrhp_method_match u_match (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_data_ff),
      .last_byte   (in_last_ff),
      .method_code (method_code)
   );

   hrhp_phase_fsm u_phase (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .tag       (tag)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= in_data_ff;
         out_tag_ff  <= tag;
         out_code_ff <= method_code;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.byte_out    = out_byte_ff;
   assign rsp_bus.role        = out_tag_ff.role;
   assign rsp_bus.field_start = out_tag_ff.field_start;
   assign rsp_bus.method_code = out_code_ff;
   assign rsp_bus.last_out    = out_last_ff;

   `HRHP_ASSERT(a_stalled_input_blocks, clock, reset,
      in_valid_ff && !advance |-> !req_bus.ready)
   `HRHP_ASSERT(a_held_result_stable, clock, reset,
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_byte_ff))
   `HRHP_ASSERT_NEVER(a_no_start_on_method_or_skip, clock, reset,
      out_valid_ff && out_tag_ff.field_start &&
      (out_tag_ff.role == hrhp_pkg::ROLE_METHOD || out_tag_ff.role == hrhp_pkg::ROLE_SKIP))

endmodule

// File: src/hrhp_method_match.sv
`include "assert_macros.svh"

module hrhp_method_match (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output logic [2:0] method_code
);

   logic [hrhp_pkg::METH_COUNT-1:0] cand_ff;
   logic [hrhp_pkg::METH_COUNT-1:0] cand_in;
   logic [2:0]                      pos_ff;
   logic [2:0]                      pos_in;
   logic [2:0]                      seen;
   logic [hrhp_pkg::METH_COUNT-1:0] cand_now;

   always_comb begin
      cand_now = cand_ff;
      seen     = 3'd7;
      if (pos_ff != 3'd7) begin
         seen = pos_ff + 3'd1;
         for (int c = 0; c < hrhp_pkg::METH_COUNT; c++) begin
            if (pos_ff < hrhp_pkg::METH_LEN[c] && data_byte != hrhp_pkg::METH_TEXT[c][pos_ff]) begin
               cand_now[c] = 1'b0;
            end
         end
      end
      // lowest index wins
      method_code = hrhp_pkg::CODE_ERROR;
      for (int c = hrhp_pkg::METH_COUNT - 1; c >= 0; c--) begin
         if (cand_now[c] && hrhp_pkg::METH_LEN[c] <= seen) begin
            method_code = 3'(c);
         end
      end
   end

   always_comb begin
      cand_in = cand_ff;
      pos_in  = pos_ff;
      if (advance) begin
         if (last_byte) begin
            cand_in = hrhp_pkg::CAND_ALL;
            pos_in  = 3'd0;
         end else begin
            cand_in = cand_now;
            pos_in  = seen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= hrhp_pkg::CAND_ALL;
         pos_ff  <= 3'd0;
      end else begin
         cand_ff <= cand_in;
         pos_ff  <= pos_in;
      end
   end

   `HRHP_ASSERT(a_match_restart, clock, reset,
      advance && last_byte |=> cand_ff == hrhp_pkg::CAND_ALL && pos_ff == 3'd0)
   `HRHP_ASSERT(a_cand_shrinks, clock, reset,
      advance && !last_byte |=> (cand_ff & ~$past(cand_ff)) == '0)

endmodule

// File: src/hrhp_phase_fsm.sv
`include "assert_macros.svh"

module hrhp_phase_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output hrhp_pkg::tag_type tag
);

   logic [3:0] phase_ff;
   logic [3:0] phase_in;
   logic       open_ff;
   logic       open_in;
   logic [3:0] phase_nxt;
   logic       open_nxt;
   logic       is_sp;
   logic       is_cr;
   logic       is_lf;

   assign is_sp = data_byte == hrhp_pkg::CHAR_SPACE;
   assign is_cr = data_byte == hrhp_pkg::CHAR_CR;
   assign is_lf = data_byte == hrhp_pkg::CHAR_LF;

   always_comb begin
      tag.role        = hrhp_pkg::ROLE_SKIP;
      tag.field_start = 1'b0;
      phase_nxt       = phase_ff;
      open_nxt        = open_ff;
      unique case (phase_ff)
         hrhp_pkg::PH_METHOD: begin
            if (is_sp) begin
               phase_nxt = hrhp_pkg::PH_URL;
               open_nxt  = 1'b0;
            end else begin
               tag.role = hrhp_pkg::ROLE_METHOD;
            end
         end
         hrhp_pkg::PH_URL: begin
            if (is_sp) begin
               phase_nxt = hrhp_pkg::PH_VERSION;
               open_nxt  = 1'b0;
            end else begin
               tag.role        = hrhp_pkg::ROLE_URL;
               tag.field_start = !open_ff;
               open_nxt        = 1'b1;
            end
         end
         hrhp_pkg::PH_VERSION: begin
            if (is_cr) begin
               phase_nxt = hrhp_pkg::PH_VER_SKIP;
               open_nxt  = 1'b0;
            end else if (is_lf) begin
               phase_nxt = hrhp_pkg::PH_KEY_FIRST;
               open_nxt  = 1'b0;
            end else begin
               tag.role        = hrhp_pkg::ROLE_VERSION;
               tag.field_start = !open_ff;
               open_nxt        = 1'b1;
            end
         end
         hrhp_pkg::PH_VER_SKIP: begin
            phase_nxt = hrhp_pkg::PH_KEY_FIRST;
            open_nxt  = 1'b0;
         end
         hrhp_pkg::PH_KEY_FIRST: begin
            tag.role        = hrhp_pkg::ROLE_KEY;
            tag.field_start = 1'b1;
            phase_nxt       = hrhp_pkg::PH_KEY;
            open_nxt        = 1'b0;
         end
         hrhp_pkg::PH_KEY: begin
            if (data_byte == hrhp_pkg::CHAR_COLON) begin
               phase_nxt = hrhp_pkg::PH_COLON_SKIP;
               open_nxt  = 1'b0;
            end else begin
               tag.role = hrhp_pkg::ROLE_KEY;
            end
         end
         hrhp_pkg::PH_COLON_SKIP: begin
            phase_nxt = hrhp_pkg::PH_VALUE;
            open_nxt  = 1'b0;
         end
         hrhp_pkg::PH_VALUE: begin
            if (is_cr) begin
               phase_nxt = hrhp_pkg::PH_VAL_SKIP;
               open_nxt  = 1'b0;
            end else if (is_lf) begin
               phase_nxt = hrhp_pkg::PH_LINE_CHECK;
               open_nxt  = 1'b0;
            end else begin
               tag.role        = hrhp_pkg::ROLE_VALUE;
               tag.field_start = !open_ff;
               open_nxt        = 1'b1;
            end
         end
         hrhp_pkg::PH_VAL_SKIP: begin
            phase_nxt = hrhp_pkg::PH_LINE_CHECK;
            open_nxt  = 1'b0;
         end
         hrhp_pkg::PH_LINE_CHECK: begin
            if (is_cr) begin
               phase_nxt = hrhp_pkg::PH_END_SKIP;
               open_nxt  = 1'b0;
            end else if (is_lf) begin
               phase_nxt = hrhp_pkg::PH_BODY;
               open_nxt  = 1'b0;
            end else begin
               tag.role        = hrhp_pkg::ROLE_KEY;
               tag.field_start = 1'b1;
               phase_nxt       = hrhp_pkg::PH_KEY;
               open_nxt        = 1'b0;
            end
         end
         hrhp_pkg::PH_END_SKIP: begin
            phase_nxt = hrhp_pkg::PH_BODY;
            open_nxt  = 1'b0;
         end
         default: begin
            phase_nxt       = hrhp_pkg::PH_BODY;
            tag.role        = hrhp_pkg::ROLE_BODY;
            tag.field_start = !open_ff;
            open_nxt        = 1'b1;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      open_in  = open_ff;
      if (advance) begin
         if (last_byte) begin
            phase_in = hrhp_pkg::PH_METHOD;
            open_in  = 1'b0;
         end else begin
            phase_in = phase_nxt;
            open_in  = open_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrhp_pkg::PH_METHOD;
         open_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         open_ff  <= open_in;
      end
   end

   `HRHP_ASSERT(a_phase_restart, clock, reset,
      advance && last_byte |=> phase_ff == hrhp_pkg::PH_METHOD && !open_ff)
   `HRHP_ASSERT_NEVER(a_no_phase_beyond_body, clock, reset, phase_ff > hrhp_pkg::PH_BODY)

endmodule

// File: bench/hrhp_tag_checker.sv
module hrhp_tag_checker
   import hrhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hrhp_req_if        req_bus,
   hrhp_rsp_if        rsp_bus,
   output int         mismatch_count,
   output int         pending_count,
   output int         checked_count
);

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] role;
      logic       start;
      logic [2:0] code;
      logic       ends;
   } byte_tag_type;

   byte_tag_type expected_tags [$];

   logic [3:0]            tag_phase;
   logic [METH_COUNT-1:0] name_alive;
   logic [2:0]            byte_count;
   logic                  field_seen;

   int n_mismatch = 0;
   int n_checked  = 0;

   function automatic void clear_request();
      tag_phase  = PH_METHOD;
      name_alive = CAND_ALL;
      byte_count = 3'd0;
      field_seen = 1'b0;
   endfunction

   function automatic void enter_phase(logic [3:0] ph);
      tag_phase  = ph;
      field_seen = 1'b0;
   endfunction

   function automatic logic field_begins();
      logic first;
      first      = !field_seen;
      field_seen = 1'b1;
      return first;
   endfunction

   function automatic byte_tag_type tag_byte(logic [7:0] b, logic ends);
      byte_tag_type r;
      logic [2:0]   seen;
      logic         found;
      r.data  = b;
      r.role  = ROLE_SKIP;
      r.start = 1'b0;
      r.ends  = ends;
      // method name match over the first seven bytes only
      if (byte_count < 3'd7) begin
         for (int c = 0; c < METH_COUNT; c++)
            if (byte_count < METH_LEN[c] && b != METH_TEXT[c][byte_count])
               name_alive[c] = 1'b0;
         seen = byte_count + 3'd1;
      end else begin
         seen = 3'd7;
      end
      byte_count = seen;
      r.code = CODE_ERROR;
      found  = 1'b0;
      for (int c = 0; c < METH_COUNT; c++)
         if (!found && name_alive[c] && METH_LEN[c] <= seen) begin
            r.code = 3'(c);
            found  = 1'b1;
         end
      case (tag_phase)
         PH_METHOD: begin
            if (b == CHAR_SPACE) enter_phase(PH_URL);
            else r.role = ROLE_METHOD;
         end
         PH_URL: begin
            if (b == CHAR_SPACE) enter_phase(PH_VERSION);
            else begin
               r.role  = ROLE_URL;
               r.start = field_begins();
            end
         end
         PH_VERSION: begin
            if (b == CHAR_CR) enter_phase(PH_VER_SKIP);
            else if (b == CHAR_LF) enter_phase(PH_KEY_FIRST);
            else begin
               r.role  = ROLE_VERSION;
               r.start = field_begins();
            end
         end
         PH_VER_SKIP: enter_phase(PH_KEY_FIRST);
         PH_KEY_FIRST: begin
            r.role  = ROLE_KEY;
            r.start = 1'b1;
            enter_phase(PH_KEY);
         end
         PH_KEY: begin
            if (b == CHAR_COLON) enter_phase(PH_COLON_SKIP);
            else r.role = ROLE_KEY;
         end
         PH_COLON_SKIP: enter_phase(PH_VALUE);
         PH_VALUE: begin
            if (b == CHAR_CR) enter_phase(PH_VAL_SKIP);
            else if (b == CHAR_LF) enter_phase(PH_LINE_CHECK);
            else begin
               r.role  = ROLE_VALUE;
               r.start = field_begins();
            end
         end
         PH_VAL_SKIP: enter_phase(PH_LINE_CHECK);
         PH_LINE_CHECK: begin
            if (b == CHAR_CR) enter_phase(PH_END_SKIP);
            else if (b == CHAR_LF) enter_phase(PH_BODY);
            else begin
               r.role  = ROLE_KEY;
               r.start = 1'b1;
               enter_phase(PH_KEY);
            end
         end
         PH_END_SKIP: enter_phase(PH_BODY);
         default: begin
            tag_phase = PH_BODY;
            r.role    = ROLE_BODY;
            r.start   = field_begins();
         end
      endcase
      if (ends) clear_request();
      return r;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_mismatch++;
      end
   endtask

   always @(posedge clock) begin
      byte_tag_type want;
      if (reset) begin
         expected_tags.delete();
         clear_request();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_tags.size() == 0) begin
               $error("result beat with nothing expected: byte_out %0d", rsp_bus.byte_out);
               n_mismatch++;
            end else begin
               want = expected_tags.pop_front();
               compare_field("byte_out", int'(want.data), int'(rsp_bus.byte_out));
               compare_field("role", int'(want.role), int'(rsp_bus.role));
               compare_field("field_start", int'(want.start), int'(rsp_bus.field_start));
               compare_field("method_code", int'(want.code), int'(rsp_bus.method_code));
               compare_field("last_out", int'(want.ends), int'(rsp_bus.last_out));
               n_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_tags.push_back(tag_byte(req_bus.data_byte, req_bus.last_byte));
      end
      mismatch_count <= n_mismatch;
      pending_count  <= expected_tags.size();
      checked_count  <= n_checked;
   end

endmodule

// File: bench/tb_top.sv
module tb_top;
   import hrhp_pkg::*;

   localparam int IDLE_PCT       = 16;
   localparam int BYTE_TARGET    = 850;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;

   hrhp_req_if req_bus ();
   hrhp_rsp_if rsp_bus ();

   int mismatch_count;
   int pending_count;
   int checked_count;

   int   bytes_sent;
   int   requests_sent;
   int   idle_cycles = 0;
   logic steady;
   logic drained;

   logic [7:0] msg_q [$];

   http_request_head_parser_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hrhp_tag_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic ends);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= ends;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      steady = (bytes_sent >= 300 && bytes_sent < 450);
   endtask

   task automatic send_msg();
      for (int i = 0; i < msg_q.size(); i++)
         send_byte(msg_q[i], i == msg_q.size() - 1);
      requests_sent++;
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         msg_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      if ($urandom_range(9) == 0) b = 8'($urandom);
      else b = 8'($urandom_range(8'h7e, 8'h21));
      if (b == CHAR_COLON) b = 8'h2f;
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(5))
         0: return CHAR_SPACE;
         1: return CHAR_CR;
         2: return CHAR_LF;
         3: return CHAR_COLON;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void push_line_end();
      if ($urandom_range(1)) begin
         msg_q.push_back(CHAR_CR);
         msg_q.push_back(($urandom_range(3) != 0) ? CHAR_LF : 8'($urandom));
      end else begin
         msg_q.push_back(CHAR_LF);
      end
   endfunction

   function automatic void push_name(int name, int len);
      for (int i = 0; i < len; i++)
         msg_q.push_back(METH_TEXT[name][i]);
   endfunction

   function automatic void build_request();
      int pick;
      int name;
      int n;
      msg_q.delete();
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(20, 1);
         repeat (n) msg_q.push_back(noise_byte());
         return;
      end
      pick = $urandom_range(9);
      name = $urandom_range(METH_COUNT - 1);
      if (pick < METH_COUNT) begin
         push_name(pick, METH_LEN[pick]);
      end else if (pick == 7) begin
         push_name(name, $urandom_range(METH_LEN[name] - 1, 1));
      end else if (pick == 8) begin
         repeat ($urandom_range(8, 1)) msg_q.push_back(8'($urandom_range(8'h5a, 8'h41)));
      end else begin
         push_name(name, METH_LEN[name]);
         repeat ($urandom_range(3, 1)) msg_q.push_back(8'($urandom_range(8'h5a, 8'h41)));
      end
      msg_q.push_back(CHAR_SPACE);
      repeat ($urandom_range(5)) msg_q.push_back(text_byte());
      msg_q.push_back(CHAR_SPACE);
      repeat ($urandom_range(4)) msg_q.push_back(text_byte());
      push_line_end();
      repeat ($urandom_range(3)) begin
         msg_q.push_back(($urandom_range(4) == 0) ? 8'($urandom) : text_byte());
         repeat ($urandom_range(3)) msg_q.push_back(text_byte());
         msg_q.push_back(CHAR_COLON);
         msg_q.push_back(($urandom_range(9) < 7) ? CHAR_SPACE : 8'($urandom));
         repeat ($urandom_range(4)) msg_q.push_back(text_byte());
         push_line_end();
      end
      push_line_end();
      repeat ($urandom_range(5)) msg_q.push_back(8'($urandom));
      // cut short now and then so delimiters go missing
      if ($urandom_range(6) == 0) begin
         n = $urandom_range(msg_q.size(), 1);
         msg_q = msg_q[0:n-1];
      end
   endfunction

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      bytes_sent    = 0;
      requests_sent = 0;
      steady        = 1'b0;
      drained       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one-byte request, no name matched
      msg_q.delete();
      msg_q.push_back(8'h00);
      send_msg();

      // cr and lf line ends, blank line, body
      msg_q.delete();
      push_text("GET a V");
      msg_q.push_back(CHAR_CR);
      msg_q.push_back(8'h00);
      push_text("K:xv");
      msg_q.push_back(CHAR_LF);
      msg_q.push_back(CHAR_CR);
      msg_q.push_back(8'h00);
      msg_q.push_back(8'hff);
      send_msg();

      // longest name, ends on its last letter
      msg_q.delete();
      push_text("OPTIONS");
      send_msg();

      while (bytes_sent < BYTE_TARGET) begin
         build_request();
         send_msg();
         if (!drained && bytes_sent >= 600) begin
            drained = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
      end
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      $display("sent %0d requests, %0d bytes; %0d tagged beats checked",
               requests_sent, bytes_sent, checked_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
